@@ src/sha256_message_digest_defines.svh @@
// Assertion macros shared by the checker
`ifndef SHA256_MESSAGE_DIGEST_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_DEFINES_SVH
`define SHA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha256 check failed");
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha256 check failed");
`endif

@@ src/sha_pkg.sv @@
package sha_pkg;
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out;

    // queue entry: one whole block plus how to finish
    typedef struct packed {
        logic [511:0] block;
        logic         last;
    } t_blk;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [255:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
            32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
            32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
            32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
            32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
            32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[idx];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction
endpackage

@@ src/sha_front.sv @@
// Packs bytes into blocks and builds the padding blocks.
module sha_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sha_pkg::t_in  i_data,
    output logic          o_blk_valid,
    input  logic          i_blk_ready,
    output sha_pkg::t_blk o_blk
);
    import sha_pkg::*;

    typedef enum logic [1:0] {
        S_TAKE = 2'b01,
        S_PAD2 = 2'b10
    } t_state;

    t_state        r_state, n_state;
    logic [511:0]  r_block, n_block;
    logic [5:0]    r_pos, n_pos;
    logic [63:0]   r_len, n_len;
    logic          r_bv, n_bv;
    t_blk          r_out, n_out;

    logic          accept;
    logic          can_push;

    assign can_push = !r_bv || i_blk_ready;
    assign o_ready  = (r_state == S_TAKE) && can_push;
    assign accept   = i_valid && o_ready;
    assign o_blk_valid = r_bv;
    assign o_blk    = r_out;

    always_comb begin
        logic [511:0] blk;
        logic [5:0]   pos;
        logic [63:0]  len;
        logic         wrapped;
        n_state = r_state;
        n_block = r_block;
        n_pos   = r_pos;
        n_len   = r_len;
        n_bv    = r_bv && !i_blk_ready;
        n_out   = r_out;
        blk     = r_block;
        pos     = r_pos;
        len     = r_len;
        wrapped = 1'b0;
        unique case (r_state)
            S_TAKE: begin
                if (accept) begin
                    if (i_data.byte_valid) begin
                        blk[(7'd63 - 7'(pos)) * 8 +: 8] = i_data.data_byte;
                        len = len + 64'd8;
                        pos = pos + 6'd1;
                        wrapped = (pos == 6'd0);
                    end
                    if (wrapped && !i_data.end_of_message) begin
                        n_bv  = 1'b1;
                        n_out = '{block: blk, last: 1'b0};
                    end else if (i_data.end_of_message) begin
                        // a full block goes out as is, padding follows alone
                        if (wrapped) begin
                            n_bv    = 1'b1;
                            n_out   = '{block: blk, last: 1'b0};
                            n_state = S_PAD2;
                            blk     = '0;
                            blk[511] = 1'b1;
                        end else begin
                            blk[(7'd63 - 7'(pos)) * 8 +: 8] = PAD_BYTE;
                            for (int p = 0; p < 64; p++)
                                if (6'(p) > pos) blk[(63 - p) * 8 +: 8] = 8'h00;
                            n_bv = 1'b1;
                            if (pos >= 6'd56) begin
                                n_out   = '{block: blk, last: 1'b0};
                                n_state = S_PAD2;
                                blk     = '0;
                            end else begin
                                blk[63:0] = len;
                                n_out = '{block: blk, last: 1'b1};
                                len = '0;
                            end
                        end
                        pos = '0;
                    end
                    n_block = blk;
                    n_pos   = pos;
                    n_len   = len;
                end
            end
            S_PAD2: begin
                if (can_push) begin
                    n_bv  = 1'b1;
                    n_out = '{block: {r_block[511:64], r_len}, last: 1'b1};
                    n_len = '0;
                    n_state = S_TAKE;
                end
            end
            default: n_state = S_TAKE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TAKE;
            r_pos   <= '0;
            r_len   <= '0;
            r_bv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_bv    <= n_bv;
        end
        r_block <= n_block;
        r_out   <= n_out;
    end
endmodule

@@ src/sha_queue.sv @@
// Small block queue between packer and compressor.
module sha_queue #(
    parameter int DEPTH = sha_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sha_pkg::t_blk i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output sha_pkg::t_blk o_data
);
    import sha_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_blk            r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            push, pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
        if (push) r_mem[r_wp] <= i_data;
    end
endmodule

@@ src/sha_core.sv @@
// 64-round compressor, one round a cycle; after the last block of a message it streams the digest.
module sha_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sha_pkg::t_blk i_blk,
    output logic          o_valid,
    input  logic          i_ready,
    output sha_pkg::t_out o_data
);
    import sha_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ROUND = 4'b0010,
        S_ADD   = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state       r_state;
    logic [255:0] r_hash;
    logic [31:0]  r_w [16];
    logic [31:0]  r_v [8];
    logic [5:0]   r_rnd;
    logic         r_last;
    logic [2:0]   r_idx;
    logic         r_ov;
    t_out         r_out;

    logic [31:0]  w_new, wv, t1, t2, s0, s1, e1, a0;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ov;
    assign o_data  = r_out;

    // window shifts left: r_w[0] is the oldest word
    always_comb begin
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        wv = r_w[0];
        e1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        a0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        t1 = r_v[7] + e1 + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + round_k(r_rnd) + wv;
        t2 = a0 + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hash  <= INIT_HASH;
            r_ov    <= 1'b0;
            r_rnd   <= '0;
            r_idx   <= '0;
        end else begin
            // while emitting, the emit arm below owns the valid flag
            if (r_ov && i_ready && r_state != S_EMIT) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    for (int i = 0; i < 16; i++) r_w[i] <= i_blk.block[(15 - i) * 32 +: 32];
                    for (int i = 0; i < 8; i++)  r_v[i] <= r_hash[(7 - i) * 32 +: 32];
                    r_last  <= i_blk.last;
                    r_rnd   <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                    r_w[15] <= w_new;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_rnd  <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++)
                        r_hash[(7 - i) * 32 +: 32] <= r_hash[(7 - i) * 32 +: 32] + r_v[i];
                    r_idx   <= '0;
                    r_state <= r_last ? S_EMIT : S_IDLE;
                end
                S_EMIT: if (!r_ov || i_ready) begin
                    r_ov  <= 1'b1;
                    r_out <= '{digest_word: r_hash[(3'd7 - r_idx) * 32 +: 32],
                               word_index: r_idx, last_word: (r_idx == 3'd7)};
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        r_hash  <= INIT_HASH;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ src/sha256_message_digest.sv @@
// Bytes are taken one a cycle while the block queue has room; input waits on an extra pad block.
// The compressor loads each 64-byte block, runs its 64 rounds and adds the result into the hash; it
// takes the next block from the queue only once that is done. Digest: 8 words, one a cycle while the
// receiver is ready, the first valid after the last block's rounds and hash addition.
// Synchronous active-low reset restores the initial hash and an empty message.
module sha256_message_digest #(
    parameter int QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sha_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output sha_pkg::t_out o_data
);
    import sha_pkg::*;

    t_blk fq_data, qc_data;
    logic fq_valid, fq_ready, qc_valid, qc_ready;

    sha_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data,
        .o_blk_valid(fq_valid), .i_blk_ready(fq_ready), .o_blk(fq_data));

    sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk, .i_rst_n, .i_valid(fq_valid), .o_ready(fq_ready), .i_data(fq_data),
        .o_valid(qc_valid), .i_ready(qc_ready), .o_data(qc_data));

    sha_core u_core (
        .i_clk, .i_rst_n, .i_valid(qc_valid), .o_ready(qc_ready), .i_blk(qc_data),
        .o_valid, .i_ready, .o_data);
endmodule

@@ src/sha_checker.sv @@
`include "sha256_message_digest_defines.svh"
module sha_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input sha_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_ready,
    input sha_pkg::t_out o_data
);
    `SHA_ASSERT_IMPL(a_last_idx, i_clk, i_rst_n, o_valid, (o_data.last_word == (o_data.word_index == 3'd7)))
    `SHA_ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, o_valid && i_ready && !o_data.last_word, (!o_valid || o_data.word_index == $past(o_data.word_index) + 3'd1))
    `SHA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, (o_valid && $stable(o_data)))
endmodule

bind sha256_message_digest sha_checker u_chk (.*);
